@@ design/vector_mean_removal_top_assert.svh @@
// Assertion macros used by the checker file of the mean removal block.
`ifndef VECTOR_MEAN_REMOVAL_TOP_ASSERT_SVH
`define VECTOR_MEAN_REMOVAL_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define VMR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define VMR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/vmr_pkg.sv @@
// Shared constants and types of the vector mean removal block.
package vmr_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_ITEMS   = 64;
    localparam int DEPTH       = 64;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W       = VALUE_WIDTH + ADDR_W;
    localparam int STEP_W      = $clog2(SUM_W + 1);

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] force_x;
        logic [VALUE_WIDTH-1:0] force_y;
        logic [VALUE_WIDTH-1:0] force_z;
        logic                   set_end;
    } t_in;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] centered_x;
        logic [VALUE_WIDTH-1:0] centered_y;
        logic [VALUE_WIDTH-1:0] centered_z;
        logic                   final_result;
    } t_out;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              acc_en;
        logic              sum_clr;
        logic              div_start;
        logic              mean_ld;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              out_load;
        logic              out_last;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_sts;

endpackage

@@ design/vmr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module vmr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/vmr_div.sv @@
// Bit-serial signed divider: sum divided by item count, truncating toward zero.
module vmr_div import vmr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic [SUM_W-1:0] o_quot,
    output logic             o_done
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic              r_neg;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W:0]    trial;
    logic              fits;
    logic [SUM_W-1:0]  mag;

    assign mag   = i_dividend[SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == STEP_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Shift dividend bits out of the top while quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_quo <= mag;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], fits};
            r_rem <= fits ? CNT_W'(trial - {1'b0, r_div}) : trial[CNT_W-1:0];
        end
    end

    assign o_quot = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign o_done = r_done;

endmodule

@@ design/vmr_dp.sv @@
// Datapath: vector stores, component sums, dividers and centering output register.
module vmr_dp import vmr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_out o_out
);

    logic [VALUE_WIDTH-1:0] rd_x, rd_y, rd_z;
    logic [SUM_W-1:0]       r_sum_x, r_sum_y, r_sum_z;
    logic [SUM_W-1:0]       quot_x, quot_y, quot_z;
    logic                   done_x, done_y, done_z;
    logic [VALUE_WIDTH:0]   r_mean_x, r_mean_y, r_mean_z;
    t_out                   r_out;
    logic [CNT_W-1:0]       count;

    function automatic logic [SUM_W-1:0] f_ext(input logic [VALUE_WIDTH-1:0] v);
        f_ext = {{(SUM_W-VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v};
    endfunction

    // Subtract the mean and clamp to the signed value range.
    function automatic logic [VALUE_WIDTH-1:0] f_center(
        input logic [VALUE_WIDTH-1:0] v,
        input logic [VALUE_WIDTH:0]   m
    );
        logic [VALUE_WIDTH+1:0] d;
        d = {{2{v[VALUE_WIDTH-1]}}, v} - {m[VALUE_WIDTH], m};
        if (d[VALUE_WIDTH+1:VALUE_WIDTH-1] == 3'b000 ||
            d[VALUE_WIDTH+1:VALUE_WIDTH-1] == 3'b111) begin
            f_center = d[VALUE_WIDTH-1:0];
        end else if (d[VALUE_WIDTH+1]) begin
            f_center = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        end else begin
            f_center = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end
    endfunction

    vmr_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_ram_x (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.wr_en),
        .i_wr_addr(i_cmd.wr_addr),
        .i_wr_data(i_in.force_x),
        .i_rd_en  (i_cmd.rd_en),
        .i_rd_addr(i_cmd.rd_addr),
        .o_rd_data(rd_x)
    );

    vmr_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_ram_y (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.wr_en),
        .i_wr_addr(i_cmd.wr_addr),
        .i_wr_data(i_in.force_y),
        .i_rd_en  (i_cmd.rd_en),
        .i_rd_addr(i_cmd.rd_addr),
        .o_rd_data(rd_y)
    );

    vmr_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_ram_z (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.wr_en),
        .i_wr_addr(i_cmd.wr_addr),
        .i_wr_data(i_in.force_z),
        .i_rd_en  (i_cmd.rd_en),
        .i_rd_addr(i_cmd.rd_addr),
        .o_rd_data(rd_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_sum_z <= '0;
        end else if (i_cmd.sum_clr) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_sum_z <= '0;
        end else if (i_cmd.acc_en) begin
            r_sum_x <= r_sum_x + f_ext(i_in.force_x);
            r_sum_y <= r_sum_y + f_ext(i_in.force_y);
            r_sum_z <= r_sum_z + f_ext(i_in.force_z);
        end
    end

    // The write address of the start cycle is the final item count.
    assign count = (i_cmd.wr_addr == '0) ? CNT_W'(DEPTH) : CNT_W'(i_cmd.wr_addr);

    vmr_div u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_dividend(r_sum_x), .i_divisor(count), .o_quot(quot_x), .o_done(done_x)
    );

    vmr_div u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_dividend(r_sum_y), .i_divisor(count), .o_quot(quot_y), .o_done(done_y)
    );

    vmr_div u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_dividend(r_sum_z), .i_divisor(count), .o_quot(quot_z), .o_done(done_z)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.mean_ld) begin
            r_mean_x <= quot_x[VALUE_WIDTH:0];
            r_mean_y <= quot_y[VALUE_WIDTH:0];
            r_mean_z <= quot_z[VALUE_WIDTH:0];
        end
        if (i_cmd.out_load) begin
            r_out.centered_x   <= f_center(rd_x, r_mean_x);
            r_out.centered_y   <= f_center(rd_y, r_mean_y);
            r_out.centered_z   <= f_center(rd_z, r_mean_z);
            r_out.final_result <= i_cmd.out_last;
        end
    end

    // All three dividers run in lockstep.
    assign o_sts.div_done = done_x & done_y & done_z;
    assign o_out          = r_out;

endmodule

@@ design/vmr_ctrl.sv @@
// Controller: load, divide and emit sequencing with the output beat handshake.
module vmr_ctrl import vmr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_set_end,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_LOAD   = 2'd0;
    localparam logic [1:0] S_DSTART = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_rd_pend, n_rd_pend;
    logic             r_rd_last, n_rd_last;
    logic             r_out_valid, n_out_valid;
    logic             in_acc;
    logic             issue;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] idx_inc;

    assign in_acc  = i_valid && (r_state == S_LOAD);
    assign cnt_inc = r_count + 1'b1;
    assign idx_inc = r_idx + 1'b1;
    // Read the next vector only when the output register is free by the next cycle.
    assign issue   = (r_state == S_EMIT) && !r_rd_pend && (r_idx != r_count) &&
                     (!r_out_valid || !i_stall);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_rd_pend   = r_rd_pend;
        n_rd_last   = r_rd_last;
        n_out_valid = r_out_valid;

        o_cmd           = '0;
        o_cmd.wr_addr   = r_count[ADDR_W-1:0];
        o_cmd.rd_addr   = r_idx[ADDR_W-1:0];
        o_cmd.out_last  = r_rd_last;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.acc_en = 1'b1;
                    n_count      = cnt_inc;
                    if (i_set_end || cnt_inc == CNT_W'(MAX_ITEMS)) begin
                        n_state = S_DSTART;
                    end
                end
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.sum_clr   = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.mean_ld = 1'b1;
                    n_idx         = '0;
                    n_state       = S_EMIT;
                end
            end
            S_EMIT: begin
                if (issue) begin
                    o_cmd.rd_en = 1'b1;
                    n_idx       = idx_inc;
                    n_rd_pend   = 1'b1;
                    n_rd_last   = (idx_inc == r_count);
                end
                if (r_rd_pend) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_rd_pend      = 1'b0;
                    if (r_rd_last) begin
                        n_count = '0;
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_pend   <= 1'b0;
            r_rd_last   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_rd_pend   <= n_rd_pend;
            r_rd_last   <= n_rd_last;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_LOAD);
    assign o_valid = r_out_valid;

endmodule

@@ design/vector_mean_removal_top.sv @@
// Top level of the vector mean removal block.
// Loads a set of up to MAX_ITEMS signed Q16.16 3D vectors, one beat per cycle, into three
// RAMs while summing each component. The set closes on a beat with set_end or on beat
// number MAX_ITEMS. The block then starts the bit-serial dividers, waits for them to finish,
// latches the mean, and emits every stored vector minus the mean in load order, saturated,
// with final_result on the last beat. Each emitted beat goes through the registered RAM
// read and then the output register; the next read waits until that read has loaded the
// output register and the register is free or being taken. Input is stalled after the
// closing beat until the last result has entered the output register. The stores need no
// clearing after reset.
module vector_mean_removal_top import vmr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_in,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_out
);

    t_cmd cmd;
    t_sts sts;

    vmr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_set_end(i_in.set_end),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    vmr_dp u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in),
        .i_cmd  (cmd),
        .o_sts  (sts),
        .o_out  (o_out)
    );

endmodule

@@ design/vmr_checker.sv @@
// Port-level checker for the mean removal block and its bind to the top level.
`include "vector_mean_removal_top_assert.svh"

module vmr_checker import vmr_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_in  i_in,
    input logic o_valid,
    input logic i_stall,
    input t_out o_out
);

    `VMR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out), "stalled output beat changed")

    `VMR_ASSERT_NEXT(a_end_stalls, i_clk, i_rst_n, i_valid && !o_stall && i_in.set_end, o_stall, "input not stalled after set end")

    `VMR_ASSERT_NOW(a_emit_stalls, i_clk, i_rst_n, o_valid && !o_out.final_result, o_stall, "input open during emission")

    `VMR_ASSERT_NEXT(a_final_gap, i_clk, i_rst_n, o_valid && !i_stall && o_out.final_result, !o_valid, "result right after final beat")

endmodule

bind vector_mean_removal_top vmr_checker u_vmr_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_stall(o_stall),
    .i_in   (i_in),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_out  (o_out)
);
